>>> rtl/core/glcd_pkg.sv
// Package: item types, panel constants and bus codes for the pixel plotter.
package glcd_pkg;

    localparam int COLUMNS_PER_CONTROLLER = 64;
    localparam int PANEL_ROWS             = 64;
    localparam int COL_W                  = $clog2(COLUMNS_PER_CONTROLLER);
    localparam int RUN_MAX                = 4;
    localparam int RUN_CNT_W              = $clog2(RUN_MAX + 1);
    localparam int RUN_IDX_W              = $clog2(RUN_MAX);

    localparam logic [7:0] CMD_SET_COLUMN = 8'h40;
    localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;

    localparam logic [1:0] KIND_COMMAND    = 2'd0;
    localparam logic [1:0] KIND_DUMMY_READ = 2'd1;
    localparam logic [1:0] KIND_DATA_READ  = 2'd2;
    localparam logic [1:0] KIND_DATA_WRITE = 2'd3;

    localparam logic OP_PLOT  = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] x;
        logic [6:0] y;
        logic       set;
        logic [7:0] read_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] bus_kind;
        logic       chip_select;
        logic [7:0] bus_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic             reply_pending;
        logic [COL_W-1:0] pending_column;
        logic             pending_side;
        logic [2:0]       pending_bit;
        logic             pending_level;
    } pend_t;

    typedef struct packed {
        logic [RUN_CNT_W-1:0]         count;
        out_item_t [RUN_MAX-1:0]      txn;
    } run_t;

endpackage

>>> rtl/core/glcd_decode.sv
// Decode: turns one item and the pending state into a run of bus transactions.
module glcd_decode (
    input  glcd_pkg::in_item_t item,
    input  glcd_pkg::pend_t    state,
    output glcd_pkg::run_t     run,
    output glcd_pkg::pend_t    state_next
);
    import glcd_pkg::*;

    localparam logic [8:0] X_MAX = 9'(2 * COLUMNS_PER_CONTROLLER);
    localparam logic [8:0] X_HALF = 9'(COLUMNS_PER_CONTROLLER);
    localparam logic [7:0] COL_OFS = 8'(COLUMNS_PER_CONTROLLER);
    localparam logic [6:0] Y_MAX = 7'(PANEL_ROWS);

    logic             x_ok;
    logic             y_ok;
    logic             side;
    logic [7:0]       x_m1;
    logic [7:0]       col_full;
    logic [COL_W-1:0] column;
    logic [6:0]       row;
    logic [2:0]       page;
    logic [7:0]       mask;
    logic [7:0]       data;
    logic [7:0]       col_cmd;

    assign x_ok     = (item.x != 8'd0) && ({1'b0, item.x} <= X_MAX);
    assign y_ok     = (item.y != 7'd0) && (item.y <= Y_MAX);
    assign side     = {1'b0, item.x} > X_HALF;
    assign x_m1     = item.x - 8'd1;
    assign col_full = side ? x_m1 - COL_OFS : x_m1;
    assign column   = col_full[COL_W-1:0];
    assign row      = item.y - 7'd1;
    assign page     = 3'(row >> 3);
    assign mask     = 8'd1 << state.pending_bit;
    assign data     = state.pending_level ? (item.read_byte | mask)
                                          : (item.read_byte & ~mask);
    assign col_cmd  = CMD_SET_COLUMN | 8'(state.pending_column);

    always_comb begin
        run        = '0;
        state_next = state;
        if (item.operation == OP_PLOT) begin
            if (!state.reply_pending && x_ok && y_ok) begin
                state_next.reply_pending  = 1'b1;
                state_next.pending_column = column;
                state_next.pending_side   = side;
                state_next.pending_bit    = row[2:0];
                state_next.pending_level  = item.set;
                run.count  = RUN_CNT_W'(4);
                run.txn[0] = '{KIND_COMMAND, side, CMD_SET_COLUMN | 8'(column), 1'b0};
                run.txn[1] = '{KIND_COMMAND, side, CMD_SET_PAGE | 8'(page), 1'b0};
                run.txn[2] = '{KIND_DUMMY_READ, side, 8'd0, 1'b0};
                run.txn[3] = '{KIND_DATA_READ, side, 8'd0, 1'b1};
            end
        end else begin
            if (state.reply_pending) begin
                state_next.reply_pending = 1'b0;
                run.count  = RUN_CNT_W'(2);
                run.txn[0] = '{KIND_COMMAND, state.pending_side, col_cmd, 1'b0};
                run.txn[1] = '{KIND_DATA_WRITE, state.pending_side, data, 1'b1};
            end
        end
    end

endmodule

>>> rtl/core/glcd_emit.sv
// Emitter: holds one run of transactions and sends them out one item per cycle while m_ready is high.
module glcd_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                run_valid,
    input  glcd_pkg::run_t      run,
    output logic                run_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output glcd_pkg::out_item_t m_item
);
    import glcd_pkg::*;

    out_item_t [RUN_MAX-1:0] buf_reg, buf_next;
    logic [RUN_IDX_W-1:0]    idx_reg, idx_next;
    logic [RUN_CNT_W-1:0]    rem_reg, rem_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;
    logic                    out_adv;

    assign out_adv   = !m_valid_reg || m_ready;
    assign run_ready = (rem_reg == '0) ||
                       ((rem_reg == RUN_CNT_W'(1)) && out_adv);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_comb begin
        buf_next     = buf_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (out_adv) begin
            if (rem_reg != '0) begin
                m_valid_next = 1'b1;
                m_item_next  = buf_reg[idx_reg];
                idx_next     = idx_reg + RUN_IDX_W'(1);
                rem_next     = rem_reg - RUN_CNT_W'(1);
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (run_valid && run_ready) begin
            buf_next = run.txn;
            idx_next = '0;
            rem_next = run.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
        buf_reg    <= buf_next;
        m_item_reg <= m_item_next;
    end

endmodule

>>> rtl/core/glcd_pixel_plotter.sv
// Top level: pixel plotter that issues read-modify-write bus runs to a two-controller panel.
//
// Input channel s_valid/s_ready/s_item carries plot requests (operation 0) and
// bytes returned by the panel data read (operation 1). Result channel
// m_valid/m_ready/m_item carries one bus transaction per item; last marks the
// final transaction of the run caused by one input item.
// A valid plot gives four transactions (set column, set page, dummy read, data
// read); a reply to a pending plot gives two (set column, data write).
// Out-of-range plots, plots while a reply is pending and unexpected replies
// give nothing.
// The first transaction of a run passes through the input register, the emitter's
// run buffer and its result register. The emitter sends one transaction per cycle
// while m_ready is high and loads the next run as the last transaction of the run
// before is issued; items that give nothing leave the input register at once.
// Reset clears the pending reply and empties both the input and result stages.
// When the receiver stalls, the result item holds and the input register fills,
// after which s_ready drops until the run drains.
module glcd_pixel_plotter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  glcd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output glcd_pkg::out_item_t m_item
);
    import glcd_pkg::*;

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg, in_item_next;
    pend_t    state_reg, state_next, dec_state;
    run_t     run;
    logic     run_ready;
    logic     take;

    glcd_decode u_decode (
        .item       (in_item_reg),
        .state      (state_reg),
        .run        (run),
        .state_next (dec_state)
    );

    glcd_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_valid (in_valid_reg && (run.count != '0)),
        .run       (run),
        .run_ready (run_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    assign take    = in_valid_reg && ((run.count == '0) || run_ready);
    assign s_ready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        state_next    = state_reg;
        if (take) begin
            state_next    = dec_state;
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
        in_item_reg <= in_item_next;
    end

endmodule

>>> verif/testbench.sv
// Testbench: directed and random read-modify-write pixel plots checked against a bus predictor.
module testbench;
    import glcd_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int HOLD_CYCLES     = 80;
    localparam int RANDOM_RUNS     = 64;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    glcd_pixel_plotter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    pend_t     shadow;
    out_item_t expected_txns[$];
    int        mismatches;
    int        txns_checked;
    int        plots_done;
    int        replies_done;
    int        ignored_items;
    int        productive_items;
    bit        source_gaps;
    bit        sink_stalls;
    bit        hold_request;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_txn(logic [1:0] kind, logic side, logic [7:0] data,
                                      logic last_flag);
        out_item_t t;
        t.bus_kind    = kind;
        t.chip_select = side;
        t.bus_byte    = data;
        t.last        = last_flag;
        expected_txns.push_back(t);
    endfunction

    function automatic int predict_bus_run(in_item_t it);
        logic       side;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] page;
        logic [7:0] mask;
        logic [7:0] data;
        logic [7:0] held_column;
        if (it.operation == OP_PLOT) begin
            if (shadow.reply_pending || it.x == 0 || it.x > 2 * COLUMNS_PER_CONTROLLER ||
                it.y == 0 || it.y > PANEL_ROWS)
                return 0;
            side = (it.x > COLUMNS_PER_CONTROLLER);
            if (side)
                column = it.x - 8'd1 - 8'(COLUMNS_PER_CONTROLLER);
            else
                column = it.x - 8'd1;
            row  = {1'b0, it.y} - 8'd1;
            page = row >> 3;
            shadow.reply_pending  = 1'b1;
            shadow.pending_column = column[COL_W-1:0];
            shadow.pending_side   = side;
            shadow.pending_bit    = row[2:0];
            shadow.pending_level  = it.set;
            queue_txn(KIND_COMMAND, side, CMD_SET_COLUMN | column, 1'b0);
            queue_txn(KIND_COMMAND, side, CMD_SET_PAGE | page, 1'b0);
            queue_txn(KIND_DUMMY_READ, side, 8'h00, 1'b0);
            queue_txn(KIND_DATA_READ, side, 8'h00, 1'b1);
            return 4;
        end
        if (!shadow.reply_pending) return 0;
        mask = 8'h01 << shadow.pending_bit;
        if (shadow.pending_level)
            data = it.read_byte | mask;
        else
            data = it.read_byte & ~mask;
        held_column = 8'(shadow.pending_column);
        shadow.reply_pending = 1'b0;
        queue_txn(KIND_COMMAND, shadow.pending_side, CMD_SET_COLUMN | held_column, 1'b0);
        queue_txn(KIND_DATA_WRITE, shadow.pending_side, data, 1'b1);
        return 2;
    endfunction

    function automatic in_item_t plot_req(int px, int py, bit level);
        in_item_t it;
        it.operation = OP_PLOT;
        it.x         = 8'(px);
        it.y         = 7'(py);
        it.set       = level;
        it.read_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic in_item_t reply_item(int data);
        in_item_t it;
        it.operation = OP_REPLY;
        it.x         = 8'($urandom_range(0, 255));
        it.y         = 7'($urandom_range(0, 127));
        it.set       = 1'($urandom_range(0, 1));
        it.read_byte = 8'(data);
        return it;
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it.operation = 1'($urandom_range(0, 1));
        it.x         = 8'($urandom_range(0, 255));
        it.y         = 7'($urandom_range(0, 127));
        it.set       = 1'($urandom_range(0, 1));
        it.read_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        int idle;
        int produced;
        idle = source_gaps ? pick_gap() : 0;
        @(negedge aclk);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        produced = predict_bus_run(it);
        if (produced == 0) begin
            ignored_items++;
        end else begin
            productive_items++;
            if (it.operation == OP_PLOT)
                plots_done++;
            else
                replies_done++;
        end
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_txns.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic test_corner_pixels();
        send_item(plot_req(1, 1, 1'b1));
        send_item(reply_item(8'h00));
        send_item(plot_req(128, 64, 1'b0));
        send_item(reply_item(8'hFF));
        send_item(plot_req(64, 8, 1'b1));
        send_item(reply_item(8'h7E));
        send_item(plot_req(65, 9, 1'b0));
        send_item(reply_item(8'hFF));
        wait_drain();
    endtask

    task automatic test_rejected_items();
        send_item(plot_req(0, 5, 1'b1));
        send_item(plot_req(129, 5, 1'b1));
        send_item(plot_req(255, 127, 1'b0));
        send_item(plot_req(10, 0, 1'b1));
        send_item(plot_req(10, 65, 1'b1));
        send_item(plot_req(10, 127, 1'b0));
        send_item(reply_item(8'hFF));
        send_item(reply_item(8'h00));
        wait_drain();
    endtask

    task automatic test_plot_while_pending();
        send_item(plot_req(10, 20, 1'b1));
        send_item(plot_req(100, 40, 1'b0));
        send_item(plot_req(0, 0, 1'b1));
        send_item(reply_item(8'h3C));
        wait_drain();
    endtask

    task automatic test_backpressure();
        source_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (6) begin
            send_item(plot_req($urandom_range(1, 128), $urandom_range(1, 64),
                               1'($urandom_range(0, 1))));
            send_item(reply_item($urandom_range(0, 255)));
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int target;
        int n;
        target = productive_items + RANDOM_RUNS;
        n = 0;
        while (productive_items < target) begin
            // alternate stretches with and without gaps
            source_gaps = ((n / 20) % 3) != 2;
            sink_stalls = ((n / 30) % 4) != 3;
            if ($urandom_range(0, 99) < 70) begin
                send_item(plot_req($urandom_range(1, 128), $urandom_range(1, 64),
                                   1'($urandom_range(0, 1))));
                if ($urandom_range(0, 9) != 0)
                    send_item(reply_item($urandom_range(0, 255)));
            end else begin
                send_item(noise_item());
            end
            n++;
        end
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        wait_drain();
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : bus_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            txns_checked++;
            if (expected_txns.size() == 0) begin
                $error("unexpected bus item: %p", m_item);
                mismatches++;
            end else begin
                want = expected_txns.pop_front();
                if (m_item.bus_kind !== want.bus_kind) begin
                    $error("bus_kind: expected %0d, got %0d", want.bus_kind, m_item.bus_kind);
                    mismatches++;
                end
                if (m_item.chip_select !== want.chip_select) begin
                    $error("chip_select: expected %0d, got %0d",
                           want.chip_select, m_item.chip_select);
                    mismatches++;
                end
                if (m_item.bus_byte !== want.bus_byte) begin
                    $error("bus_byte: expected %02h, got %02h", want.bus_byte, m_item.bus_byte);
                    mismatches++;
                end
                if (m_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_item.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        repeat (WATCHDOG_CYCLES) @(posedge aclk);
        $display("Timed out after %0d cycles", WATCHDOG_CYCLES);
        $display("FAILURE");
        $finish;
    end

    initial begin
        s_valid      = 1'b0;
        s_item       = '0;
        aresetn      = 1'b0;
        shadow       = '0;
        source_gaps  = 1'b1;
        sink_stalls  = 1'b1;
        hold_request = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_corner_pixels();
        test_rejected_items();
        test_plot_while_pending();
        test_backpressure();
        test_random_traffic();

        $display("Run covered %0d plots and %0d replies, %0d items ignored,",
                 plots_done, replies_done, ignored_items);
        $display("with %0d bus items checked under random stalls and one long hold-off.",
                 txns_checked);
        if (mismatches == 0 && expected_txns.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
